FILE: rtl/core/tdar_pkg.sv
// Shared types and constants of the 2-D autoregressive field filter.
package tdar_pkg;

    localparam int CFG_INDEX_BITS  = 3;
    localparam int CFG_DATA_BITS   = 32;
    localparam int WIDTH_CFG_BITS  = 11;
    localparam int HEIGHT_CFG_BITS = 13;
    localparam int ROW_BITS        = 12;
    localparam int HEIGHT_LIMIT    = 4096;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_WIDTH  = 3'd0,
        CFG_HEIGHT = 3'd1,
        CFG_KIND   = 3'd2,
        CFG_COEF_H = 3'd3,
        CFG_COEF_V = 3'd4
    } t_cfg_index;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RHV,
        ST_SN,
        ST_LEFT,
        ST_UP,
        ST_DIAG,
        ST_ACC,
        ST_DONE
    } t_state;

    // products of the shared multiplier
    typedef enum logic [2:0] {
        OP_NONE,
        OP_RHV,
        OP_SN,
        OP_LEFT,
        OP_UP,
        OP_DIAG
    } t_op;

    typedef struct packed {
        logic                     en;
        logic [CFG_INDEX_BITS-1:0] idx;
        logic [CFG_DATA_BITS-1:0]  data;
    } t_cfg_wr;

    typedef struct packed {
        logic load_in;
        logic ram_rd;
        logic cap_up;
        t_op  mul_op;
        t_op  acc_op;
        logic finish;
        logic first_row;
        logic first_col;
        logic stoch;
        logic eor;
        logic eof;
    } t_cmd;

endpackage

FILE: rtl/core/tdar_if.sv
// Channel interfaces: pixel input, result output and register write.
interface tdar_pix_if #(
    parameter int SAMPLE_BITS = 24,
    parameter int COEF_BITS   = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] noise_sample;
    logic signed [SAMPLE_BITS-1:0] pixel_mean;
    logic signed [SAMPLE_BITS-1:0] pixel_scale;
    logic signed [COEF_BITS-1:0]   pixel_coef_horizontal;
    logic signed [COEF_BITS-1:0]   pixel_coef_vertical;

    modport source (
        output valid, noise_sample, pixel_mean, pixel_scale,
               pixel_coef_horizontal, pixel_coef_vertical,
        input  ready
    );
    modport sink (
        input  valid, noise_sample, pixel_mean, pixel_scale,
               pixel_coef_horizontal, pixel_coef_vertical,
        output ready
    );
endinterface

interface tdar_res_if #(
    parameter int SAMPLE_BITS = 24
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] field_value;
    logic                          end_of_row;
    logic                          end_of_frame;

    modport source (output valid, field_value, end_of_row, end_of_frame, input ready);
    modport sink   (input valid, field_value, end_of_row, end_of_frame, output ready);
endinterface

interface tdar_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [tdar_pkg::CFG_INDEX_BITS-1:0] reg_index;
    logic [tdar_pkg::CFG_DATA_BITS-1:0]  wr_data;

    modport source (output valid, reg_index, wr_data, input ready);
    modport sink   (input valid, reg_index, wr_data, output ready);
endinterface

FILE: rtl/core/two_d_autoregressive_field_filter.sv
// Top level of the 2-D autoregressive field filter.
//
// Pixels enter in raster order on i_pix (valid/ready); one result per pixel
// leaves on o_res with end_of_row and end_of_frame flags. Registers are
// written on i_cfg (index, data), which is always ready; write them only
// while no pixel is in flight.
// Only one pixel is in flight at a time: after a pixel is taken, the single
// shared multiplier forms rh*rv, scale*noise, rh*left, rv*up and
// rhv*neighbor in turn, then the result is saturated and written; the row
// memory is read as the pixel is taken.
// The result sits in an output register: the next pixel is taken while it
// waits. If the receiver stalls longer, the following pixel finishes its
// arithmetic and holds until the output register frees up.
// Reset returns size, mode and coefficients to their defaults and restarts
// at the frame origin. The row memory is not cleared; the first row of
// every frame never uses what it reads from it.
module two_d_autoregressive_field_filter #(
    parameter int MAX_WIDTH   = 1024,
    parameter int SAMPLE_BITS = 24,
    parameter int COEF_BITS   = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    tdar_pix_if.sink      i_pix,
    tdar_res_if.source    o_res,
    tdar_cfg_if.sink      i_cfg
);

    localparam int CW = $clog2(MAX_WIDTH);

    tdar_pkg::t_cfg_wr cfg_wr;
    tdar_pkg::t_cmd    cmd;
    logic [CW-1:0]     ram_addr;
    logic              in_ready;
    logic              out_valid;

    assign i_cfg.ready = 1'b1;
    assign cfg_wr.en   = i_cfg.valid;
    assign cfg_wr.idx  = i_cfg.reg_index;
    assign cfg_wr.data = i_cfg.wr_data;

    tdar_ctrl #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr    (cfg_wr),
        .i_in_valid  (i_pix.valid),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .i_out_ready (o_res.ready),
        .o_cmd       (cmd),
        .o_ram_addr  (ram_addr)
    );

    tdar_dp #(
        .MAX_WIDTH   (MAX_WIDTH),
        .SAMPLE_BITS (SAMPLE_BITS),
        .COEF_BITS   (COEF_BITS)
    ) u_dp (
        .i_clk                   (i_clk),
        .i_rst_n                 (i_rst_n),
        .i_cfg_wr                (cfg_wr),
        .i_cmd                   (cmd),
        .i_ram_addr              (ram_addr),
        .i_noise_sample          (i_pix.noise_sample),
        .i_pixel_mean            (i_pix.pixel_mean),
        .i_pixel_scale           (i_pix.pixel_scale),
        .i_pixel_coef_horizontal (i_pix.pixel_coef_horizontal),
        .i_pixel_coef_vertical   (i_pix.pixel_coef_vertical),
        .o_field_value           (o_res.field_value),
        .o_end_of_row            (o_res.end_of_row),
        .o_end_of_frame          (o_res.end_of_frame)
    );

    assign i_pix.ready = in_ready;
    assign o_res.valid = out_valid;

    // one pixel in flight: no second transaction right after the first
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pix.valid && i_pix.ready) |=> !i_pix.ready)
        else $error("pixel taken while another is in flight");

    // row memory data is captured the cycle after the read
    a_up_capture: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pix.valid && i_pix.ready) |=> cmd.cap_up)
        else $error("row memory read not followed by capture");

    // never overwrite a result that is still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.finish |-> (!o_res.valid || o_res.ready))
        else $error("result register overwritten while stalled");

    // after a result is loaded it is shown and the input opens again
    a_finish_effect: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.finish |=> (o_res.valid && i_pix.ready))
        else $error("finished pixel not presented");

endmodule

FILE: rtl/core/tdar_ram.sv
// Generic simple dual-port RAM with registered read.
module tdar_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/core/tdar_ctrl.sv
// Controller: sequencer, raster position counters and size/mode registers.
module tdar_ctrl #(
    parameter int MAX_WIDTH = 1024,
    localparam int CW       = $clog2(MAX_WIDTH)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tdar_pkg::t_cfg_wr i_cfg_wr,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output tdar_pkg::t_cmd    o_cmd,
    output logic [CW-1:0]     o_ram_addr
);

    localparam int WB = tdar_pkg::WIDTH_CFG_BITS;
    localparam int HB = tdar_pkg::HEIGHT_CFG_BITS;
    localparam int RB = tdar_pkg::ROW_BITS;
    localparam int XW = ($clog2(MAX_WIDTH + 1) > WB) ? $clog2(MAX_WIDTH + 1) : WB;

    tdar_pkg::t_state r_state, n_state;
    logic [WB-1:0]    r_width;
    logic [HB-1:0]    r_height;
    logic             r_kind;
    logic [CW-1:0]    r_col, n_col;
    logic [RB-1:0]    r_row, n_row;
    logic             r_out_valid, n_out_valid;

    logic [XW-1:0] w_eff;
    logic [HB-1:0] h_eff;
    logic [XW-1:0] col_ext;
    logic [XW-1:0] col_inc;
    logic          wrap;
    logic [CW-1:0] col_adj;
    logic [HB-1:0] row_bump;
    logic [RB-1:0] row_adj;
    logic [HB-1:0] row_inc;
    logic [CW-1:0] col_step;
    logic [RB-1:0] row_step;
    logic          accept;
    logic          advance;

    // clamp frame size to the supported range
    always_comb begin
        w_eff = XW'(r_width);
        if (r_width == '0) begin
            w_eff = XW'(1);
        end else if (XW'(r_width) > XW'(MAX_WIDTH)) begin
            w_eff = XW'(MAX_WIDTH);
        end
        h_eff = r_height;
        if (r_height == '0) begin
            h_eff = HB'(1);
        end else if (r_height > HB'(tdar_pkg::HEIGHT_LIMIT)) begin
            h_eff = HB'(tdar_pkg::HEIGHT_LIMIT);
        end
    end

    // position of the pixel about to be taken, after a size change
    always_comb begin
        col_ext  = XW'(r_col);
        wrap     = col_ext >= w_eff;
        col_adj  = wrap ? '0 : r_col;
        row_bump = HB'(r_row) + (wrap ? HB'(1) : HB'(0));
        row_adj  = (row_bump >= h_eff) ? '0 : row_bump[RB-1:0];
    end

    // position after the current pixel
    always_comb begin
        col_inc  = col_ext + XW'(1);
        row_inc  = HB'(r_row) + HB'(1);
        col_step = col_inc[CW-1:0];
        row_step = r_row;
        if (col_inc >= w_eff) begin
            col_step = '0;
            row_step = (row_inc >= h_eff) ? '0 : row_inc[RB-1:0];
        end
    end

    assign accept  = (r_state == tdar_pkg::ST_IDLE) && i_in_valid;
    assign advance = (r_state == tdar_pkg::ST_DONE) && (!r_out_valid || i_out_ready);

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (accept) begin
            n_col = col_adj;
            n_row = row_adj;
        end else if (advance) begin
            n_col = col_step;
            n_row = row_step;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (advance) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tdar_pkg::ST_IDLE: if (i_in_valid) n_state = tdar_pkg::ST_RHV;
            tdar_pkg::ST_RHV:  n_state = tdar_pkg::ST_SN;
            tdar_pkg::ST_SN:   n_state = tdar_pkg::ST_LEFT;
            tdar_pkg::ST_LEFT: n_state = tdar_pkg::ST_UP;
            tdar_pkg::ST_UP:   n_state = tdar_pkg::ST_DIAG;
            tdar_pkg::ST_DIAG: n_state = tdar_pkg::ST_ACC;
            tdar_pkg::ST_ACC:  n_state = tdar_pkg::ST_DONE;
            tdar_pkg::ST_DONE: if (advance) n_state = tdar_pkg::ST_IDLE;
            default:           n_state = tdar_pkg::ST_IDLE;
        endcase
    end

    // datapath commands
    always_comb begin
        o_cmd           = '0;
        o_cmd.mul_op    = tdar_pkg::OP_NONE;
        o_cmd.acc_op    = tdar_pkg::OP_NONE;
        o_cmd.first_row = (r_row == '0);
        o_cmd.first_col = (r_col == '0);
        o_cmd.stoch     = r_kind;
        o_cmd.eor       = (col_ext == w_eff - XW'(1));
        o_cmd.eof       = o_cmd.eor && (HB'(r_row) == h_eff - HB'(1));
        o_in_ready      = 1'b0;
        o_ram_addr      = r_col;
        unique case (r_state)
            tdar_pkg::ST_IDLE: begin
                o_in_ready    = 1'b1;
                o_ram_addr    = col_adj;
                o_cmd.load_in = i_in_valid;
                o_cmd.ram_rd  = i_in_valid;
            end
            tdar_pkg::ST_RHV: begin
                o_cmd.cap_up = 1'b1;
                o_cmd.mul_op = tdar_pkg::OP_RHV;
            end
            tdar_pkg::ST_SN: begin
                o_cmd.mul_op = tdar_pkg::OP_SN;
                o_cmd.acc_op = tdar_pkg::OP_RHV;
            end
            tdar_pkg::ST_LEFT: begin
                o_cmd.mul_op = tdar_pkg::OP_LEFT;
                o_cmd.acc_op = tdar_pkg::OP_SN;
            end
            tdar_pkg::ST_UP: begin
                o_cmd.mul_op = tdar_pkg::OP_UP;
                o_cmd.acc_op = tdar_pkg::OP_LEFT;
            end
            tdar_pkg::ST_DIAG: begin
                o_cmd.mul_op = tdar_pkg::OP_DIAG;
                o_cmd.acc_op = tdar_pkg::OP_UP;
            end
            tdar_pkg::ST_ACC: begin
                o_cmd.acc_op = tdar_pkg::OP_DIAG;
            end
            tdar_pkg::ST_DONE: begin
                o_cmd.finish = advance;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tdar_pkg::ST_IDLE;
            r_width     <= WB'(1024);
            r_height    <= HB'(1024);
            r_kind      <= 1'b0;
            r_col       <= '0;
            r_row       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_col       <= n_col;
            r_row       <= n_row;
            r_out_valid <= n_out_valid;
            if (i_cfg_wr.en) begin
                if (i_cfg_wr.idx == tdar_pkg::CFG_WIDTH) begin
                    r_width <= i_cfg_wr.data[WB-1:0];
                end
                if (i_cfg_wr.idx == tdar_pkg::CFG_HEIGHT) begin
                    r_height <= i_cfg_wr.data[HB-1:0];
                end
                if (i_cfg_wr.idx == tdar_pkg::CFG_KIND) begin
                    r_kind <= i_cfg_wr.data[0];
                end
            end
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

FILE: rtl/core/tdar_dp.sv
// Datapath: shared multiplier, rounding accumulator, neighbor registers, row memory.
module tdar_dp #(
    parameter int MAX_WIDTH   = 1024,
    parameter int SAMPLE_BITS = 24,
    parameter int COEF_BITS   = 16,
    localparam int CW         = $clog2(MAX_WIDTH)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  tdar_pkg::t_cfg_wr             i_cfg_wr,
    input  tdar_pkg::t_cmd                i_cmd,
    input  logic [CW-1:0]                 i_ram_addr,
    input  logic signed [SAMPLE_BITS-1:0] i_noise_sample,
    input  logic signed [SAMPLE_BITS-1:0] i_pixel_mean,
    input  logic signed [SAMPLE_BITS-1:0] i_pixel_scale,
    input  logic signed [COEF_BITS-1:0]   i_pixel_coef_horizontal,
    input  logic signed [COEF_BITS-1:0]   i_pixel_coef_vertical,
    output logic signed [SAMPLE_BITS-1:0] o_field_value,
    output logic                          o_end_of_row,
    output logic                          o_end_of_frame
);

    localparam int SF   = SAMPLE_BITS - 8;
    localparam int CF   = COEF_BITS - 2;
    localparam int RHVW = COEF_BITS + 2;
    localparam int MA   = (SAMPLE_BITS > RHVW) ? SAMPLE_BITS : RHVW;
    localparam int MB   = (SAMPLE_BITS > COEF_BITS) ? SAMPLE_BITS : COEF_BITS;
    localparam int PW   = MA + MB;
    localparam int AW   = PW + 4;

    localparam logic signed [AW-1:0] HALF_C = AW'(1) <<< (CF - 1);
    localparam logic signed [AW-1:0] HALF_S = AW'(1) <<< (SF - 1);
    localparam logic signed [AW-1:0] SAT_HI = (AW'(1) <<< (SAMPLE_BITS - 1)) - AW'(1);
    localparam logic signed [AW-1:0] SAT_LO = ~SAT_HI;

    logic signed [SAMPLE_BITS-1:0] r_noise, r_scale, r_up, r_left, r_diag, r_field;
    logic signed [COEF_BITS-1:0]   r_ch, r_cv, r_fix_h, r_fix_v;
    logic signed [RHVW-1:0]        r_rhv;
    logic signed [PW-1:0]          r_prod;
    logic signed [AW-1:0]          r_acc;
    logic                          r_eor, r_eof;

    logic signed [COEF_BITS-1:0]   rh, rv;
    logic signed [SAMPLE_BITS-1:0] x_val;
    logic signed [MA-1:0]          mul_a;
    logic signed [MB-1:0]          mul_b;
    logic signed [AW-1:0]          p_ext, rnd_c, rnd_s;
    logic signed [SAMPLE_BITS-1:0] sat;
    logic [SAMPLE_BITS-1:0]        ram_rd_data;
    logic                          use_left, use_up, use_diag;

    assign rh = i_cmd.stoch ? r_ch : r_fix_h;
    assign rv = i_cmd.stoch ? r_cv : r_fix_v;

    // neighbor scaled by rh*rv: left on the first row, up on the first column
    always_comb begin
        if (i_cmd.first_row) begin
            x_val = r_left;
        end else if (i_cmd.first_col) begin
            x_val = r_up;
        end else begin
            x_val = r_diag;
        end
    end

    assign use_left = !i_cmd.first_col;
    assign use_up   = !i_cmd.first_row;
    assign use_diag = (!i_cmd.first_row && !i_cmd.first_col)
                   || (i_cmd.stoch && (i_cmd.first_row ^ i_cmd.first_col));

    always_comb begin
        unique case (i_cmd.mul_op)
            tdar_pkg::OP_RHV: begin
                mul_a = MA'(rh);
                mul_b = MB'(rv);
            end
            tdar_pkg::OP_SN: begin
                mul_a = MA'(r_scale);
                mul_b = MB'(r_noise);
            end
            tdar_pkg::OP_LEFT: begin
                mul_a = MA'(rh);
                mul_b = MB'(r_left);
            end
            tdar_pkg::OP_UP: begin
                mul_a = MA'(rv);
                mul_b = MB'(r_up);
            end
            tdar_pkg::OP_DIAG: begin
                mul_a = MA'(r_rhv);
                mul_b = MB'(x_val);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // round half up, then floor
    assign p_ext = AW'(r_prod);
    assign rnd_c = (p_ext + HALF_C) >>> CF;
    assign rnd_s = (p_ext + HALF_S) >>> SF;

    always_comb begin
        if (r_acc > SAT_HI) begin
            sat = SAMPLE_BITS'(SAT_HI);
        end else if (r_acc < SAT_LO) begin
            sat = SAMPLE_BITS'(SAT_LO);
        end else begin
            sat = SAMPLE_BITS'(r_acc);
        end
    end

    tdar_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_row_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.finish),
        .i_wr_addr (i_ram_addr),
        .i_wr_data (sat),
        .i_rd_en   (i_cmd.ram_rd),
        .i_rd_addr (i_ram_addr),
        .o_rd_data (ram_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left  <= '0;
            r_diag  <= '0;
            r_fix_h <= '0;
            r_fix_v <= '0;
        end else begin
            if (i_cfg_wr.en && (i_cfg_wr.idx == tdar_pkg::CFG_COEF_H)) begin
                r_fix_h <= i_cfg_wr.data[COEF_BITS-1:0];
            end
            if (i_cfg_wr.en && (i_cfg_wr.idx == tdar_pkg::CFG_COEF_V)) begin
                r_fix_v <= i_cfg_wr.data[COEF_BITS-1:0];
            end
            if (i_cmd.finish) begin
                r_left <= sat;
                r_diag <= r_up;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_noise <= i_noise_sample;
            r_scale <= i_pixel_scale;
            r_ch    <= i_pixel_coef_horizontal;
            r_cv    <= i_pixel_coef_vertical;
        end
        if (i_cmd.cap_up) begin
            r_up <= ram_rd_data;
        end
        r_prod <= mul_a * mul_b;
        if (i_cmd.load_in) begin
            r_acc <= i_cmd.stoch ? AW'(i_pixel_mean) : AW'(i_noise_sample);
        end else begin
            unique case (i_cmd.acc_op)
                tdar_pkg::OP_RHV:  r_rhv <= RHVW'(rnd_c);
                tdar_pkg::OP_SN:   if (i_cmd.stoch) r_acc <= r_acc + rnd_s;
                tdar_pkg::OP_LEFT: if (use_left) r_acc <= r_acc + rnd_c;
                tdar_pkg::OP_UP:   if (use_up) r_acc <= r_acc + rnd_c;
                tdar_pkg::OP_DIAG: if (use_diag) r_acc <= r_acc - rnd_c;
                default:           r_acc <= r_acc;
            endcase
        end
        if (i_cmd.finish) begin
            r_field <= sat;
            r_eor   <= i_cmd.eor;
            r_eof   <= i_cmd.eof;
        end
    end

    assign o_field_value  = r_field;
    assign o_end_of_row   = r_eor;
    assign o_end_of_frame = r_eof;

endmodule

FILE: verif/two_d_autoregressive_field_filter_tb.sv
// Self-checking testbench for the 2-D autoregressive field filter: directed table plus random frames.
module two_d_autoregressive_field_filter_tb;

    localparam int MAX_WIDTH   = 1024;
    localparam int SAMPLE_BITS = 24;
    localparam int COEF_BITS   = 16;
    localparam int SAMPLE_FRAC = SAMPLE_BITS - 8;
    localparam int COEF_FRAC   = COEF_BITS - 2;
    localparam longint SAT_HI  = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
    localparam longint SAT_LO  = -(longint'(1) << (SAMPLE_BITS - 1));
    localparam int RANDOM_ITEMS = 900;
    localparam int SETTLE_CYCLES = 12;
    localparam int WB = tdar_pkg::WIDTH_CFG_BITS;
    localparam int HB = tdar_pkg::HEIGHT_CFG_BITS;
    localparam int IB = tdar_pkg::CFG_INDEX_BITS;
    localparam int DB = tdar_pkg::CFG_DATA_BITS;
    localparam logic [IB-1:0] CFG_SPARE = 3'd7;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] noise;
        logic signed [SAMPLE_BITS-1:0] mean;
        logic signed [SAMPLE_BITS-1:0] scale;
        logic signed [COEF_BITS-1:0]   coef_h;
        logic signed [COEF_BITS-1:0]   coef_v;
    } t_pixel_in;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] value;
        logic                          eor;
        logic                          eof;
    } t_field_out;

    typedef struct {
        bit            is_write;
        bit            typed;
        logic [IB-1:0] reg_idx;
        logic [DB-1:0] reg_data;
        t_pixel_in     pixel;
        t_field_out    want;
    } t_step;

    logic i_clk;
    logic i_rst_n;

    tdar_pix_if #(.SAMPLE_BITS(SAMPLE_BITS), .COEF_BITS(COEF_BITS)) pix_ch ();
    tdar_res_if #(.SAMPLE_BITS(SAMPLE_BITS)) res_ch ();
    tdar_cfg_if cfg_ch ();

    two_d_autoregressive_field_filter #(
        .MAX_WIDTH  (MAX_WIDTH),
        .SAMPLE_BITS(SAMPLE_BITS),
        .COEF_BITS  (COEF_BITS)
    ) DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_pix  (pix_ch),
        .o_res  (res_ch),
        .i_cfg  (cfg_ch)
    );

    // field filter state as the testbench sees it
    logic [WB-1:0] cfg_width;
    logic [HB-1:0] cfg_height;
    bit            cfg_kind;
    longint        coef_h_reg;
    longint        coef_v_reg;
    longint        row_mem [MAX_WIDTH];
    bit            row_seen [MAX_WIDTH];
    longint        left_val;
    longint        diag_val;
    int            col_pos;
    int            row_pos;

    t_field_out pending_results [$];
    int         mismatches;
    int         results_seen;
    int         src_quiet;
    t_step      plan [$];

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #15_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    function automatic void plan_add(t_step s);
        plan.insert(plan.size(), s);
    endfunction

    function automatic int eff_width(logic [WB-1:0] raw);
        int w;
        w = raw;
        if (w == 0) w = 1;
        if (w > MAX_WIDTH) w = MAX_WIDTH;
        return w;
    endfunction

    function automatic int eff_height(logic [HB-1:0] raw);
        int h;
        h = raw;
        if (h == 0) h = 1;
        if (h > tdar_pkg::HEIGHT_LIMIT) h = tdar_pkg::HEIGHT_LIMIT;
        return h;
    endfunction

    function automatic longint round_q(longint v, int s);
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic void apply_reg(logic [IB-1:0] idx, logic [DB-1:0] data);
        case (idx)
            tdar_pkg::CFG_WIDTH:  cfg_width  = data[WB-1:0];
            tdar_pkg::CFG_HEIGHT: cfg_height = data[HB-1:0];
            tdar_pkg::CFG_KIND:   cfg_kind   = data[0];
            tdar_pkg::CFG_COEF_H: coef_h_reg = longint'($signed(data[COEF_BITS-1:0]));
            tdar_pkg::CFG_COEF_V: coef_v_reg = longint'($signed(data[COEF_BITS-1:0]));
            default: ;
        endcase
    endfunction

    function automatic t_field_out predict_pixel(t_pixel_in p);
        longint w, h, noise, mean, scale, rh, rv, rhv, up, y;
        bit at_col0, at_row0;
        t_field_out r;
        w = eff_width(cfg_width);
        h = eff_height(cfg_height);
        // a size change can leave the position outside the new frame
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos++;
        end
        if (row_pos >= h) row_pos = 0;
        noise = $signed(p.noise);
        mean  = $signed(p.mean);
        scale = $signed(p.scale);
        if (cfg_kind) begin
            rh = $signed(p.coef_h);
            rv = $signed(p.coef_v);
        end else begin
            rh = coef_h_reg;
            rv = coef_v_reg;
        end
        rhv = round_q(rh * rv, COEF_FRAC);
        at_col0 = (col_pos == 0);
        at_row0 = (row_pos == 0);
        up = row_mem[col_pos];
        if (cfg_kind) y = mean + round_q(scale * noise, SAMPLE_FRAC);
        else y = noise;
        if (at_row0 && at_col0) begin
        end else if (at_row0) begin
            y += round_q(rh * left_val, COEF_FRAC);
            if (cfg_kind) y -= round_q(rhv * left_val, COEF_FRAC);
        end else if (at_col0) begin
            y += round_q(rv * up, COEF_FRAC);
            if (cfg_kind) y -= round_q(rhv * up, COEF_FRAC);
        end else begin
            y += round_q(rh * left_val, COEF_FRAC);
            y += round_q(rv * up, COEF_FRAC);
            y -= round_q(rhv * diag_val, COEF_FRAC);
        end
        if (y > SAT_HI) y = SAT_HI;
        if (y < SAT_LO) y = SAT_LO;
        row_mem[col_pos]  = y;
        row_seen[col_pos] = 1'b1;
        diag_val = up;
        left_val = y;
        r.value = y[SAMPLE_BITS-1:0];
        r.eor   = (col_pos == w - 1);
        r.eof   = r.eor && (row_pos == h - 1);
        col_pos++;
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos++;
            if (row_pos >= h) row_pos = 0;
        end
        return r;
    endfunction

    // Shrink a width that would make a later row read a column never written.
    function automatic logic [WB-1:0] safe_width(logic [WB-1:0] raw_w,
                                                 logic [HB-1:0] raw_h);
        int w, h, c, r, prefix;
        w = eff_width(raw_w);
        h = eff_height(raw_h);
        c = col_pos;
        r = row_pos;
        if (c >= w) begin
            c = 0;
            r++;
        end
        if (r >= h) r = 0;
        if (r == 0) return raw_w;
        prefix = 0;
        while (prefix < MAX_WIDTH && row_seen[prefix]) prefix++;
        if (w <= prefix) return raw_w;
        return WB'(prefix);
    endfunction

    function automatic int idle_len(inout int quiet);
        int r;
        if (quiet > 0) begin
            quiet--;
            return 0;
        end
        r = $urandom_range(99);
        if (r < 3) begin
            quiet = $urandom_range(20, 60);
            return 0;
        end
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic signed [COEF_BITS-1:0] rand_coef();
        int r;
        r = $urandom_range(99);
        if (r < 40) return COEF_BITS'($urandom_range(0, 16383) - 8192);
        if (r < 70) return COEF_BITS'($urandom());
        if (r < 78) return {1'b0, {(COEF_BITS-1){1'b1}}};
        if (r < 85) return {1'b1, {(COEF_BITS-1){1'b0}}};
        if (r < 93) return COEF_BITS'(16384);
        return COEF_BITS'(-16384);
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] rand_sample();
        int r;
        r = $urandom_range(99);
        if (r < 65) return SAMPLE_BITS'($urandom_range(0, 2 ** 21) - 2 ** 20);
        if (r < 90) return SAMPLE_BITS'($urandom());
        if (r < 95) return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    endfunction

    function automatic t_pixel_in rand_pixel();
        t_pixel_in p;
        int r;
        p.noise  = rand_sample();
        p.mean   = rand_sample();
        r = $urandom_range(99);
        if (r < 60) p.scale = SAMPLE_BITS'($urandom_range(0, 2 * 65536) - 65536);
        else if (r < 85) p.scale = SAMPLE_BITS'($urandom());
        else p.scale = rand_sample();
        p.coef_h = rand_coef();
        p.coef_v = rand_coef();
        return p;
    endfunction

    function automatic t_step cfg_step(logic [IB-1:0] idx, logic [DB-1:0] data);
        t_step s;
        s = '{default: '0};
        s.is_write = 1'b1;
        s.reg_idx  = idx;
        s.reg_data = data;
        return s;
    endfunction

    function automatic t_step pix_step(logic [SAMPLE_BITS-1:0] noise, logic [SAMPLE_BITS-1:0] mean,
                                       logic [SAMPLE_BITS-1:0] scale, logic [COEF_BITS-1:0] ch,
                                       logic [COEF_BITS-1:0] cv);
        t_step s;
        s = '{default: '0};
        s.pixel = '{noise, mean, scale, ch, cv};
        return s;
    endfunction

    function automatic t_step lit_step(logic [SAMPLE_BITS-1:0] noise, logic [SAMPLE_BITS-1:0] value,
                                       logic eor, logic eof);
        t_step s;
        s = pix_step(noise, '0, '0, '0, '0);
        s.typed = 1'b1;
        s.want  = '{value, eor, eof};
        return s;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        mismatches++;
        if (mismatches <= 200)
            $display("result %0d: %s got %0h, expected %0h", results_seen, what, got, want);
    endtask

    // Enter and leave at a falling edge; valid stays high after the transaction.
    task automatic send_pixel(t_pixel_in p, bit typed, t_field_out lit);
        int gap;
        t_field_out want;
        gap = idle_len(src_quiet);
        if (gap > 0) begin
            pix_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        pix_ch.valid                 = 1'b1;
        pix_ch.noise_sample          = p.noise;
        pix_ch.pixel_mean            = p.mean;
        pix_ch.pixel_scale           = p.scale;
        pix_ch.pixel_coef_horizontal = p.coef_h;
        pix_ch.pixel_coef_vertical   = p.coef_v;
        @(posedge i_clk);
        while (pix_ch.ready !== 1'b1) @(posedge i_clk);
        want = predict_pixel(p);
        if (typed) want = lit;
        pending_results.insert(pending_results.size(), want);
        @(negedge i_clk);
    endtask

    task automatic write_reg(logic [IB-1:0] idx, logic [DB-1:0] data);
        cfg_ch.valid     = 1'b1;
        cfg_ch.reg_index = idx;
        cfg_ch.wr_data   = data;
        @(posedge i_clk);
        while (cfg_ch.ready !== 1'b1) @(posedge i_clk);
        apply_reg(idx, data);
        @(negedge i_clk);
    endtask

    // Drop pixel valid and wait until the block has handed back everything.
    task automatic settle();
        pix_ch.valid = 1'b0;
        wait (pending_results.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    initial begin : res_ready
        int hold;
        int quiet;
        hold  = 0;
        quiet = 0;
        res_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold > 0) begin
                res_ch.ready = 1'b0;
                hold--;
            end else begin
                res_ch.ready = 1'b1;
                hold = idle_len(quiet);
            end
        end
    end

    always @(posedge i_clk) begin : res_check
        t_field_out want;
        if (i_rst_n === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected transaction, field_value", res_ch.field_value, '0);
            end else begin
                want = pending_results.pop_front();
                if (res_ch.field_value !== want.value)
                    report_mismatch("field_value", res_ch.field_value, want.value);
                if (res_ch.end_of_row !== want.eor)
                    report_mismatch("end_of_row", res_ch.end_of_row, want.eor);
                if (res_ch.end_of_frame !== want.eof)
                    report_mismatch("end_of_frame", res_ch.end_of_frame, want.eof);
            end
        end
    end

    initial begin : stimulus
        int k, n, cap, w, h, tmp, swap_at, rand_items;
        bit pix_busy;
        t_step st;
        logic [WB-1:0] raw_w;
        logic [HB-1:0] raw_h;
        logic [DB-1:0] vals [5];
        logic [DB-1:0] data;
        int reg_bits [5];
        int order [5];

        i_rst_n = 1'b0;
        pix_ch.valid                 = 1'b0;
        pix_ch.noise_sample          = '0;
        pix_ch.pixel_mean            = '0;
        pix_ch.pixel_scale           = '0;
        pix_ch.pixel_coef_horizontal = '0;
        pix_ch.pixel_coef_vertical   = '0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.reg_index = '0;
        cfg_ch.wr_data   = '0;
        mismatches   = 0;
        results_seen = 0;
        src_quiet    = 0;

        cfg_width  = 11'd1024;
        cfg_height = 13'd1024;
        cfg_kind   = 1'b0;
        coef_h_reg = 0;
        coef_v_reg = 0;
        for (k = 0; k < MAX_WIDTH; k++) begin
            row_mem[k]  = 0;
            row_seen[k] = 1'b0;
        end
        left_val = 0;
        diag_val = 0;
        col_pos  = 0;
        row_pos  = 0;

        // reset defaults: coefficients are zero, so the noise passes straight through
        plan_add(lit_step(24'h7FFFFF, 24'h7FFFFF, 1'b0, 1'b0));
        plan_add(lit_step(24'h800000, 24'h800000, 1'b0, 1'b0));
        plan_add(cfg_step(tdar_pkg::CFG_WIDTH, 32'h0000_07FF));
        plan_add(lit_step(24'h000005, 24'h000005, 1'b0, 1'b0));
        // zero width acts as one: position wraps into the second row
        plan_add(cfg_step(tdar_pkg::CFG_WIDTH, 32'h0000_0000));
        plan_add(lit_step(24'h123456, 24'h123456, 1'b1, 1'b0));
        // zero height acts as one: a new frame starts
        plan_add(cfg_step(tdar_pkg::CFG_HEIGHT, 32'h0000_0000));
        plan_add(lit_step(24'hFFFFFF, 24'hFFFFFF, 1'b1, 1'b1));
        plan_add(cfg_step(tdar_pkg::CFG_HEIGHT, 32'h0000_1FFF));
        plan_add(cfg_step(tdar_pkg::CFG_WIDTH, 32'h0000_0003));
        plan_add(cfg_step(tdar_pkg::CFG_COEF_H, 32'h0000_7FFF));
        plan_add(cfg_step(tdar_pkg::CFG_COEF_V, 32'h0000_8000));
        plan_add(cfg_step(CFG_SPARE, 32'hFFFF_FFFF));
        // extreme coefficients drive both saturation limits
        plan_add(pix_step(24'h7FFFFF, 24'h0, 24'h0, 16'h0, 16'h0));
        plan_add(pix_step(24'h7FFFFF, 24'h0, 24'h0, 16'h0, 16'h0));
        plan_add(pix_step(24'h000001, 24'h0, 24'h0, 16'h0, 16'h0));
        plan_add(pix_step(24'h000000, 24'h0, 24'h0, 16'h0, 16'h0));
        plan_add(pix_step(24'h00ABCD, 24'h0, 24'h0, 16'h0, 16'h0));
        plan_add(pix_step(24'h800000, 24'h0, 24'h0, 16'h0, 16'h0));
        plan_add(cfg_step(tdar_pkg::CFG_HEIGHT, 32'h0000_0002));
        plan_add(cfg_step(tdar_pkg::CFG_KIND, 32'h0000_0001));
        plan_add(pix_step(24'h800000, 24'h7FFFFF, 24'h800000, 16'h7FFF, 16'h8000));
        plan_add(pix_step(24'h010000, 24'h000000, 24'h010000, 16'h2000, 16'h1000));
        plan_add(pix_step(24'h7FFFFF, 24'h800000, 24'h7FFFFF, 16'h8000, 16'h7FFF));
        plan_add(pix_step(24'h000100, 24'h001000, 24'h008000, 16'h4000, 16'hC000));
        plan_add(pix_step(24'hFFFF00, 24'h100000, 24'hFF0000, 16'h3000, 16'h2000));
        plan_add(pix_step(24'h055555, 24'hFAAAAA, 24'h00AAAA, 16'h5555, 16'hAAAA));

        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        pix_busy = 1'b0;
        foreach (plan[i]) begin
            st = plan[i];
            if (st.is_write) begin
                if (pix_busy) settle();
                pix_busy = 1'b0;
                write_reg(st.reg_idx, st.reg_data);
            end else begin
                cfg_ch.valid = 1'b0;
                send_pixel(st.pixel, st.typed, st.want);
                pix_busy = 1'b1;
            end
        end

        reg_bits[tdar_pkg::CFG_WIDTH]  = WB;
        reg_bits[tdar_pkg::CFG_HEIGHT] = HB;
        reg_bits[tdar_pkg::CFG_KIND]   = 1;
        reg_bits[tdar_pkg::CFG_COEF_H] = COEF_BITS;
        reg_bits[tdar_pkg::CFG_COEF_V] = COEF_BITS;

        rand_items = 0;
        while (rand_items < RANDOM_ITEMS) begin
            settle();
            tmp = $urandom_range(99);
            if (tmp < 60) raw_w = WB'($urandom_range(1, 8));
            else if (tmp < 85) raw_w = WB'($urandom_range(9, 40));
            else if (tmp < 90) raw_w = '0;
            else raw_w = WB'($urandom_range(1000, 2047));
            tmp = $urandom_range(99);
            if (tmp < 70) raw_h = HB'($urandom_range(1, 6));
            else if (tmp < 80) raw_h = '0;
            else if (tmp < 90) raw_h = HB'($urandom_range(7, 20));
            else raw_h = HB'($urandom_range(4090, 8191));
            raw_w = safe_width(raw_w, raw_h);

            vals[tdar_pkg::CFG_WIDTH]  = {21'd0, raw_w};
            vals[tdar_pkg::CFG_HEIGHT] = {19'd0, raw_h};
            vals[tdar_pkg::CFG_KIND]   = {31'd0, 1'($urandom_range(1))};
            vals[tdar_pkg::CFG_COEF_H] = {16'd0, rand_coef()};
            vals[tdar_pkg::CFG_COEF_V] = {16'd0, rand_coef()};
            for (k = 0; k < 5; k++) order[k] = k;
            for (k = 4; k > 0; k--) begin
                swap_at = $urandom_range(k);
                tmp = order[k];
                order[k] = order[swap_at];
                order[swap_at] = tmp;
            end
            for (k = 0; k < 5; k++) begin
                data = vals[order[k]];
                // junk above the field must be dropped by the block
                if ($urandom_range(3) == 0)
                    data |= $urandom() & ~((32'd1 << reg_bits[order[k]]) - 32'd1);
                write_reg(IB'(order[k]), data);
            end
            if ($urandom_range(7) == 0) write_reg(CFG_SPARE, $urandom());
            cfg_ch.valid = 1'b0;

            w = eff_width(raw_w);
            h = eff_height(raw_h);
            if (w > 64) begin
                n = $urandom_range(1, 20);
            end else begin
                cap = w * h * 2;
                if (cap > 80) cap = 80;
                n = $urandom_range(1, cap);
            end
            repeat (n) send_pixel(rand_pixel(), 1'b0, '0);
            rand_items += n;
        end

        pix_ch.valid = 1'b0;
        wait (pending_results.size() == 0);
        repeat (20) @(posedge i_clk);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
